[rtl/core/sct_pkg.sv]
package sct_pkg;

	localparam int MAX_SETS  = 256;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_W    = 32;
	localparam int SET_W     = $clog2(MAX_SETS);
	localparam int WAY_W     = $clog2(MAX_WAYS);
	localparam int MIN_LBITS = 5;
	localparam int MAX_LBITS = 7;
	localparam int LID_W     = ADDR_W - MIN_LBITS;
	localparam int SCNT_W    = 9;
	localparam int WCNT_W    = 4;
	localparam int LB_W      = 3;
	localparam int POL_W     = 2;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W     = 7;
	localparam int OFF_W     = MAX_LBITS;
	localparam int OLEN_W    = 8;
	localparam int CNT_W     = 32;
	localparam int LK_W      = 2;
	localparam int LFSR_W    = 16;
	localparam int LEN_CAP   = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_COUNT,
		CFG_WAYS,
		CFG_LINE_BITS,
		CFG_POLICY,
		CFG_WB_EN,
		CFG_WA_EN
	} cfg_idx_t;

	typedef enum logic [POL_W-1:0] {
		POL_FIFO,
		POL_LRU,
		POL_MRU,
		POL_RAND
	} pol_t;

	typedef enum logic [2:0] {
		EV_HIT,
		EV_MISS,
		EV_FILL,
		EV_WB,
		EV_WT
	} ev_t;

	typedef enum logic {
		MODE_LOAD,
		MODE_STORE
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_LD,
		S_SRCH,
		S_HIT,
		S_MISS,
		S_FILL,
		S_INS,
		S_WB,
		S_STFIN,
		S_WT,
		S_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] access_addr;
		logic [LEN_W-1:0]  access_length;
		logic              streaming;
	} acc_t;

	typedef struct packed {
		logic [2:0]        event_res;
		logic [ADDR_W-1:0] out_addr;
		logic [OLEN_W-1:0] out_length;
		logic              out_streaming;
		logic              is_last;
		logic [CNT_W-1:0]  load_count;
		logic [CNT_W-1:0]  store_count;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
		logic [CNT_W-1:0]  evict_count;
	} res_t;

	// one set: ordered queue of ways, front is way 0
	typedef struct packed {
		logic [MAX_WAYS-1:0][LID_W-1:0] tag;
		logic [MAX_WAYS-1:0]            vld;
		logic [MAX_WAYS-1:0]            drt;
	} row_t;

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
		return {x[0] ^ x[2] ^ x[3] ^ x[5], x[LFSR_W-1:1]};
	endfunction

	function automatic logic [ADDR_W-1:0] line_base(input logic [LID_W-1:0] cl,
			input logic [LB_W-1:0] lb);
		logic [ADDR_W-1:0] t;
		t = {cl, {MIN_LBITS{1'b0}}};
		return t << (lb - LB_W'(MIN_LBITS));
	endfunction

endpackage

[rtl/core/sct_ram.sv]
module sct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/sct_mod.sv]
module sct_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sct_pkg::LID_W-1:0]  dividend,
	input  logic [sct_pkg::SET_W:0]    divisor,
	output logic                       busy,
	output logic [sct_pkg::SET_W-1:0]  rem
);
	import sct_pkg::*;

	localparam int CW = $clog2(LID_W + 1);

	logic [LID_W-1:0] dv_q;
	logic [SET_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [SET_W:0]   trial;
	logic [SET_W:0]   diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dv_q[LID_W-1]};
	assign diff  = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(LID_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dv_q  <= dv_q << 1;
			rem_q <= (trial >= divisor) ? diff[SET_W-1:0] : trial[SET_W-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

[rtl/core/set_assoc_cache_tag_controller.sv]
// channel  | direction | handshake              | beat
// acc      | in        | acc_valid / acc_stall  | one access (load or store range)
// res      | out       | res_valid / res_stall  | one event, is_last on the final one
// cfg      | in        | cfg_we                 | register index and value
// an access is accepted, the set index remainder is found for its first line, then per line
// the set row is read, the ways are searched one at a time, events and row updates follow
// and the row is written back; a closing state ends the access
// acc_stall is high from accept until the last event of the access sits in the output register
// reset clears counters and the per-set init flags, sets config to defaults and lfsr to 1; no clearing pass is run
// a stalled output holds one event in the output register and one more in a holding stage
module set_assoc_cache_tag_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc_valid,
	output logic                          acc_stall,
	input  sct_pkg::acc_t                 acc,
	output logic                          res_valid,
	input  logic                          res_stall,
	output sct_pkg::res_t                 res,
	input  logic                          cfg_we,
	input  logic [sct_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sct_pkg::CFG_W-1:0]     cfg_wdata
);
	import sct_pkg::*;

	// configuration
	logic [SCNT_W-1:0] set_count_q;
	logic [WCNT_W-1:0] ways_q;
	logic [LB_W-1:0]   lbits_q;
	pol_t              policy_q;
	logic              wb_q;
	logic              wa_q;

	logic [SET_W:0]    eff_sets;
	logic [WCNT_W-1:0] eff_ways;
	logic [LB_W-1:0]   eff_lbits;
	logic [WAY_W-1:0]  last_way;

	// sequencer state
	state_t            state_q, state_n;
	row_t              row_q, row_n;
	logic [WAY_W-1:0]  way_q, way_n;
	logic [WAY_W-1:0]  pos_q, pos_n;
	logic [LID_W-1:0]  vtag_q, vtag_n;
	logic [LK_W-1:0]   k_q, k_n;
	logic [LK_W-1:0]   nl_last_q, nl_last_n;
	logic [LID_W-1:0]  cl_q, cl_n;
	logic [SET_W-1:0]  set_q, set_n;
	logic [OFF_W-1:0]  off_q, off_n;
	logic [LEN_W-1:0]  remb_q, remb_n;
	logic              mode_q, mode_n;
	logic              nt_q, nt_n;
	logic              ins_dirty_q, ins_dirty_n;
	logic [LFSR_W-1:0] lfsr_q, lfsr_n;
	logic [MAX_SETS-1:0] rinit_q;

	// counters
	logic [CNT_W-1:0]  load_cnt_q, store_cnt_q, hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [CNT_W-1:0]  load_cnt_n, store_cnt_n, hit_cnt_n, miss_cnt_n, evict_cnt_n;
	logic              inc_load, inc_store, inc_hit, inc_miss, inc_evict;

	// result path
	res_t              pend_q, res_q, emit_res, pend_last;
	logic              pend_v_q, res_valid_q;
	logic              can_move, emit_ok, emit_fire, move_last;
	logic              emit_req, fin_req;
	ev_t               emit_ev;
	logic [ADDR_W-1:0] emit_addr;
	logic [OLEN_W-1:0] emit_len;
	logic              emit_nt;

	// datapath helpers
	logic              acc_fire;
	logic [LEN_W-1:0]  len_c;
	logic [OLEN_W-1:0] lsize;
	logic [OFF_W-1:0]  off0;
	logic [OLEN_W-1:0] span;
	logic [LK_W-1:0]   last_rel;
	logic [LID_W-1:0]  cl0;
	logic [LID_W-1:0]  clmask;
	logic [LID_W-1:0]  cl_inc;
	logic [SET_W-1:0]  set_inc;
	logic [OLEN_W-1:0] avail;
	logic [OLEN_W-1:0] plen;
	logic [ADDR_W-1:0] laddr;
	logic [ADDR_W-1:0] paddr;
	logic              hit_w;
	logic [WAY_W-1:0]  vi;
	logic              vwb;

	// memory and remainder unit
	logic              ram_we;
	row_t              ram_rdata;
	logic              mod_start;
	logic              mod_busy;
	logic [SET_W-1:0]  mod_rem;

	sct_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(MAX_SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (set_q),
		.wdata (row_q),
		.raddr (set_q),
		.rdata (ram_rdata)
	);

	sct_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cl0),
		.divisor  (eff_sets),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	// effective configuration
	always_comb begin
		if (set_count_q == '0) begin
			eff_sets = (SET_W+1)'(1);
		end else if (set_count_q > SCNT_W'(MAX_SETS)) begin
			eff_sets = (SET_W+1)'(MAX_SETS);
		end else begin
			eff_sets = (SET_W+1)'(set_count_q);
		end
		if (ways_q == '0) begin
			eff_ways = WCNT_W'(1);
		end else if (ways_q > WCNT_W'(MAX_WAYS)) begin
			eff_ways = WCNT_W'(MAX_WAYS);
		end else begin
			eff_ways = ways_q;
		end
		if (lbits_q < LB_W'(MIN_LBITS)) begin
			eff_lbits = LB_W'(MIN_LBITS);
		end else if (lbits_q > LB_W'(MAX_LBITS)) begin
			eff_lbits = LB_W'(MAX_LBITS);
		end else begin
			eff_lbits = lbits_q;
		end
	end

	assign last_way = WAY_W'(eff_ways - 1'b1);
	assign lsize    = OLEN_W'(1) << eff_lbits;

	// access split
	assign acc_fire = acc_valid && !acc_stall;
	assign len_c    = (acc.access_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
			: acc.access_length;
	assign off0     = acc.access_addr[OFF_W-1:0] & OFF_W'(lsize - 1'b1);
	assign span     = OLEN_W'(off0) + OLEN_W'(len_c) - 1'b1;
	assign last_rel = LK_W'(span >> eff_lbits);
	assign cl0      = LID_W'(acc.access_addr >> eff_lbits);
	assign clmask   = {LID_W{1'b1}} >> (eff_lbits - LB_W'(MIN_LBITS));
	assign cl_inc   = (cl_q + LID_W'(1)) & clmask;

	always_comb begin
		if (cl_inc == '0) begin
			set_inc = '0;
		end else if ((SET_W+1)'(set_q) + 1'b1 == eff_sets) begin
			set_inc = '0;
		end else begin
			set_inc = set_q + 1'b1;
		end
	end

	assign avail = lsize - OLEN_W'(off_q);
	assign plen  = (avail > OLEN_W'(remb_q)) ? OLEN_W'(remb_q) : avail;
	assign laddr = line_base(cl_q, eff_lbits);
	assign paddr = laddr | ADDR_W'(off_q);

	// shared tag compare, one way per cycle
	assign hit_w = row_q.vld[way_q] && (row_q.tag[way_q] == cl_q);

	// result staging
	assign can_move  = !res_valid_q || !res_stall;
	assign emit_ok   = !pend_v_q || can_move;
	assign emit_fire = emit_req && emit_ok;
	assign move_last = fin_req && pend_v_q && can_move;

	assign load_cnt_n  = load_cnt_q + CNT_W'(inc_load);
	assign store_cnt_n = store_cnt_q + CNT_W'(inc_store);
	assign hit_cnt_n   = hit_cnt_q + CNT_W'(inc_hit);
	assign miss_cnt_n  = miss_cnt_q + CNT_W'(inc_miss);
	assign evict_cnt_n = evict_cnt_q + CNT_W'(inc_evict);

	always_comb begin
		emit_res.event_res     = emit_ev;
		emit_res.out_addr      = emit_addr;
		emit_res.out_length    = emit_len;
		emit_res.out_streaming = emit_nt;
		emit_res.is_last       = 1'b0;
		emit_res.load_count    = load_cnt_n;
		emit_res.store_count   = store_cnt_n;
		emit_res.hit_count     = hit_cnt_n;
		emit_res.miss_count    = miss_cnt_n;
		emit_res.evict_count   = evict_cnt_n;
	end

	always_comb begin
		pend_last         = pend_q;
		pend_last.is_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		row_n       = row_q;
		way_n       = way_q;
		pos_n       = pos_q;
		vtag_n      = vtag_q;
		k_n         = k_q;
		nl_last_n   = nl_last_q;
		cl_n        = cl_q;
		set_n       = set_q;
		off_n       = off_q;
		remb_n      = remb_q;
		mode_n      = mode_q;
		nt_n        = nt_q;
		ins_dirty_n = ins_dirty_q;
		lfsr_n      = lfsr_q;
		inc_load    = 1'b0;
		inc_store   = 1'b0;
		inc_hit     = 1'b0;
		inc_miss    = 1'b0;
		inc_evict   = 1'b0;
		emit_req    = 1'b0;
		emit_ev     = EV_HIT;
		emit_addr   = laddr;
		emit_len    = '0;
		emit_nt     = 1'b0;
		fin_req     = 1'b0;
		ram_we      = 1'b0;
		mod_start   = 1'b0;
		vi          = '0;
		vwb         = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc_fire) begin
					mode_n    = acc.mode;
					nt_n      = acc.streaming;
					off_n     = off0;
					remb_n    = len_c;
					cl_n      = cl0;
					k_n       = '0;
					nl_last_n = last_rel;
					if (acc.mode == MODE_STORE) begin
						inc_store = 1'b1;
					end else begin
						inc_load = 1'b1;
					end
					if (len_c == '0) begin
						state_n = S_FIN;
					end else begin
						mod_start = 1'b1;
						state_n   = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (!mod_busy) begin
					set_n   = mod_rem;
					state_n = S_RD;
				end
			end
			S_RD: begin
				state_n = S_LD;
			end
			S_LD: begin
				row_n = ram_rdata;
				// a set never written reads as all invalid
				if (!rinit_q[set_q]) begin
					row_n.vld = '0;
					row_n.drt = '0;
				end
				way_n   = '0;
				state_n = S_SRCH;
			end
			S_SRCH: begin
				if (hit_w) begin
					if (mode_q == MODE_LOAD) begin
						state_n = S_HIT;
					end else if (wb_q) begin
						row_n.drt[way_q] = 1'b1;
						state_n          = S_WR;
					end else begin
						state_n = S_WT;
					end
				end else if (way_q == last_way) begin
					if (mode_q == MODE_LOAD) begin
						ins_dirty_n = 1'b0;
						state_n     = S_MISS;
					end else if (wa_q && !nt_q) begin
						// store miss fills the line as a load first
						inc_load    = 1'b1;
						ins_dirty_n = 1'b0;
						state_n     = S_MISS;
					end else if (wb_q) begin
						ins_dirty_n = 1'b1;
						state_n     = S_INS;
					end else begin
						state_n = S_WT;
					end
				end else begin
					way_n = way_q + 1'b1;
				end
			end
			S_HIT: begin
				emit_req = 1'b1;
				emit_ev  = EV_HIT;
				if (emit_ok) begin
					inc_hit = 1'b1;
					if (policy_q == POL_LRU || policy_q == POL_MRU) begin
						row_n.tag[0] = row_q.tag[way_q];
						row_n.vld[0] = row_q.vld[way_q];
						row_n.drt[0] = row_q.drt[way_q];
						for (int i = 1; i < MAX_WAYS; i++) begin
							if (WAY_W'(i) <= way_q) begin
								row_n.tag[i] = row_q.tag[i-1];
								row_n.vld[i] = row_q.vld[i-1];
								row_n.drt[i] = row_q.drt[i-1];
							end
						end
					end
					state_n = S_WR;
				end
			end
			S_MISS: begin
				emit_req = 1'b1;
				emit_ev  = EV_MISS;
				if (emit_ok) begin
					inc_miss = 1'b1;
					state_n  = S_FILL;
				end
			end
			S_FILL: begin
				emit_req = 1'b1;
				emit_ev  = EV_FILL;
				emit_len = lsize;
				if (emit_ok) begin
					state_n = S_INS;
				end
			end
			S_INS: begin
				case (policy_q) inside
					POL_FIFO, POL_LRU: begin
						vi = last_way;
						for (int i = 1; i < MAX_WAYS; i++) begin
							if (WCNT_W'(i) < eff_ways) begin
								row_n.tag[i] = row_q.tag[i-1];
								row_n.vld[i] = row_q.vld[i-1];
								row_n.drt[i] = row_q.drt[i-1];
							end
						end
						pos_n = '0;
					end
					POL_MRU: begin
						vi = '0;
						for (int i = 0; i < MAX_WAYS - 1; i++) begin
							if (WCNT_W'(i + 1) < eff_ways) begin
								row_n.tag[i] = row_q.tag[i+1];
								row_n.vld[i] = row_q.vld[i+1];
								row_n.drt[i] = row_q.drt[i+1];
							end
						end
						pos_n = last_way;
					end
					default: begin
						lfsr_n = lfsr_step(lfsr_q);
						vi     = lfsr_n[WAY_W-1:0] & last_way;
						pos_n  = vi;
					end
				endcase
				vtag_n           = row_q.tag[vi];
				vwb              = row_q.vld[vi] && wb_q && row_q.drt[vi];
				row_n.tag[pos_n] = cl_q;
				row_n.vld[pos_n] = 1'b1;
				row_n.drt[pos_n] = ins_dirty_q;
				if (vwb) begin
					state_n = S_WB;
				end else if (mode_q == MODE_STORE) begin
					state_n = S_STFIN;
				end else begin
					state_n = S_WR;
				end
			end
			S_WB: begin
				emit_req  = 1'b1;
				emit_ev   = EV_WB;
				emit_addr = line_base(vtag_q, eff_lbits);
				emit_len  = lsize;
				if (emit_ok) begin
					inc_evict = 1'b1;
					state_n   = (mode_q == MODE_STORE) ? S_STFIN : S_WR;
				end
			end
			S_STFIN: begin
				if (wb_q) begin
					row_n.drt[pos_q] = 1'b1;
					state_n          = S_WR;
				end else begin
					state_n = S_WT;
				end
			end
			S_WT: begin
				emit_req  = 1'b1;
				emit_ev   = EV_WT;
				emit_addr = paddr;
				emit_len  = plen;
				emit_nt   = nt_q;
				if (emit_ok) begin
					inc_evict = 1'b1;
					state_n   = S_WR;
				end
			end
			S_WR: begin
				ram_we = 1'b1;
				if (k_q == nl_last_q) begin
					state_n = S_FIN;
				end else begin
					k_n     = k_q + 1'b1;
					cl_n    = cl_inc;
					set_n   = set_inc;
					off_n   = '0;
					remb_n  = remb_q - plen[LEN_W-1:0];
					state_n = S_RD;
				end
			end
			S_FIN: begin
				fin_req = 1'b1;
				if (!pend_v_q || can_move) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q <= SCNT_W'(MAX_SETS);
			ways_q      <= WCNT_W'(MAX_WAYS);
			lbits_q     <= LB_W'(6);
			policy_q    <= POL_LRU;
			wb_q        <= 1'b1;
			wa_q        <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SET_COUNT: set_count_q <= cfg_wdata[SCNT_W-1:0];
				CFG_WAYS:      ways_q      <= cfg_wdata[WCNT_W-1:0];
				CFG_LINE_BITS: lbits_q     <= cfg_wdata[LB_W-1:0];
				CFG_POLICY:    policy_q    <= pol_t'(cfg_wdata[POL_W-1:0]);
				CFG_WB_EN:     wb_q        <= cfg_wdata[0];
				CFG_WA_EN:     wa_q        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q      <= LFSR_W'(1);
			rinit_q     <= '0;
			load_cnt_q  <= '0;
			store_cnt_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			lfsr_q      <= lfsr_n;
			load_cnt_q  <= load_cnt_n;
			store_cnt_q <= store_cnt_n;
			hit_cnt_q   <= hit_cnt_n;
			miss_cnt_q  <= miss_cnt_n;
			evict_cnt_q <= evict_cnt_n;
			if (ram_we) begin
				rinit_q[set_q] <= 1'b1;
			end
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			// held event leaves only once the next one or the end is known
			if (emit_fire) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					res_valid_q <= 1'b1;
				end
			end
			if (move_last) begin
				pend_v_q    <= 1'b0;
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		row_q       <= row_n;
		way_q       <= way_n;
		pos_q       <= pos_n;
		vtag_q      <= vtag_n;
		k_q         <= k_n;
		nl_last_q   <= nl_last_n;
		cl_q        <= cl_n;
		set_q       <= set_n;
		off_q       <= off_n;
		remb_q      <= remb_n;
		mode_q      <= mode_n;
		nt_q        <= nt_n;
		ins_dirty_q <= ins_dirty_n;
		if (emit_fire) begin
			pend_q <= emit_res;
			if (pend_v_q) begin
				res_q <= pend_q;
			end
		end
		if (move_last) begin
			res_q <= pend_last;
		end
	end

	assign acc_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("held event left behind at end of access");

	a_emit_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && pend_v_q) |=> res_valid_q)
		else $error("held event dropped on new event");

	a_pos_in_ways: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STFIN) |-> (WCNT_W'(pos_q) < eff_ways))
		else $error("insert position beyond ways in use");

	a_line_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (k_q <= nl_last_q))
		else $error("line counter past last line");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !mod_busy) |=> (state_q == S_RD))
		else $error("set index not taken after remainder");

endmodule

[tb/sv/set_assoc_cache_tag_controller_test.sv]
`timescale 1ns / 100ps

import sct_pkg::*;

class cache_event_board;
	res_t expected_q[$];
	int   fail_cnt;

	// tag store mirror
	logic [63:0] tags [MAX_SETS*MAX_WAYS];
	bit          vld  [MAX_SETS*MAX_WAYS];
	bit          drt  [MAX_SETS*MAX_WAYS];
	logic [15:0] lfsr;
	logic [31:0] n_load, n_store, n_hit, n_miss, n_evict;

	int unsigned set_count, ways_in_use, line_bits, policy, wb_en, wa_en;
	int unsigned e_sets, e_ways, e_lbits;

	function new();
		foreach (vld[i]) begin
			vld[i] = 0;
			drt[i] = 0;
			tags[i] = '0;
		end
		lfsr = 16'h0001;
		n_load = 0; n_store = 0; n_hit = 0; n_miss = 0; n_evict = 0;
		set_count = 256; ways_in_use = 8; line_bits = 6; policy = 1;
		wb_en = 1; wa_en = 1;
		fail_cnt = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, int unsigned val);
		case (idx)
			CFG_SET_COUNT: set_count = val & 9'h1ff;
			CFG_WAYS:      ways_in_use = val & 4'hf;
			CFG_LINE_BITS: line_bits = val & 3'h7;
			CFG_POLICY:    policy = val & 2'h3;
			CFG_WB_EN:     wb_en = val & 1;
			CFG_WA_EN:     wa_en = val & 1;
			default: ;
		endcase
	endfunction

	function void push_event(ev_t ev, logic [63:0] addr, int unsigned len, bit nt);
		res_t r;
		r.event_res = ev;
		r.out_addr = addr[31:0];
		r.out_length = len[7:0];
		r.out_streaming = nt;
		r.is_last = 0;
		r.load_count = n_load;
		r.store_count = n_store;
		r.hit_count = n_hit;
		r.miss_count = n_miss;
		r.evict_count = n_evict;
		expected_q.push_back(r);
	endfunction

	function void copy_way(int unsigned dst, int unsigned src);
		tags[dst] = tags[src];
		vld[dst] = vld[src];
		drt[dst] = drt[src];
	endfunction

	function int lookup(logic [63:0] cl, int unsigned base);
		for (int w = 0; w < e_ways; w++)
			if (vld[base+w] && tags[base+w] == cl) return w;
		return -1;
	endfunction

	function int unsigned replace(logic [63:0] cl, bit dirty);
		int unsigned base, vi, pos;
		logic [63:0] vtag;
		bit vv, vd, fb;
		base = (cl % e_sets) * MAX_WAYS;
		if (policy == POL_FIFO || policy == POL_LRU) vi = base + e_ways - 1;
		else if (policy == POL_MRU) vi = base;
		else begin
			fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
			lfsr = {fb, lfsr[15:1]};
			vi = base + (lfsr & (e_ways - 1));
		end
		vtag = tags[vi]; vv = vld[vi]; vd = drt[vi];
		if (policy == POL_FIFO || policy == POL_LRU) begin
			for (int i = e_ways - 1; i > 0; i--) copy_way(base + i, base + i - 1);
			pos = 0;
		end else if (policy == POL_MRU) begin
			for (int i = 0; i + 1 < e_ways; i++) copy_way(base + i, base + i + 1);
			pos = e_ways - 1;
		end else pos = vi - base;
		tags[base+pos] = cl;
		vld[base+pos] = 1;
		drt[base+pos] = dirty;
		if (vv && wb_en && vd) begin
			n_evict++;
			push_event(EV_WB, (vtag << e_lbits) & 64'hffff_ffff, 1 << e_lbits, 0);
		end
		return pos;
	endfunction

	function int unsigned fetch_line(logic [63:0] cl);
		int unsigned base;
		int loc;
		logic [63:0] la, t;
		bit v, d;
		base = (cl % e_sets) * MAX_WAYS;
		la = (cl << e_lbits) & 64'hffff_ffff;
		loc = lookup(cl, base);
		if (loc >= 0) begin
			n_hit++;
			push_event(EV_HIT, la, 0, 0);
			if (policy == POL_LRU || policy == POL_MRU) begin
				t = tags[base+loc]; v = vld[base+loc]; d = drt[base+loc];
				for (int j = loc; j > 0; j--) copy_way(base + j, base + j - 1);
				tags[base] = t; vld[base] = v; drt[base] = d;
				return 0;
			end
			return e_ways - 1;
		end
		n_miss++;
		push_event(EV_MISS, la, 0, 0);
		push_event(EV_FILL, la, 1 << e_lbits, 0);
		return replace(cl, 0);
	endfunction

	// predict the events of one accepted access
	function void note_access(acc_t a);
		int unsigned len, lsize, off, nlines, rem, plen, base, first;
		int loc;
		logic [63:0] cl, cl0, clmask, paddr;
		first = expected_q.size();
		len = a.access_length;
		if (len > LEN_CAP) len = LEN_CAP;
		e_sets = set_count == 0 ? 1 : (set_count > MAX_SETS ? MAX_SETS : set_count);
		e_ways = ways_in_use == 0 ? 1 : (ways_in_use > MAX_WAYS ? MAX_WAYS : ways_in_use);
		e_lbits = line_bits < 5 ? 5 : (line_bits > 7 ? 7 : line_bits);
		if (a.mode == MODE_LOAD) n_load++;
		else n_store++;
		if (len == 0) return;
		lsize = 1 << e_lbits;
		off = a.access_addr & (lsize - 1);
		nlines = ((off + len - 1) >> e_lbits) + 1;
		cl0 = {32'h0, a.access_addr} >> e_lbits;
		clmask = 64'hffff_ffff >> e_lbits;
		rem = len;
		for (int k = 0; k < nlines; k++) begin
			cl = (cl0 + k) & clmask;
			plen = lsize - off;
			paddr = ((cl << e_lbits) | off) & 64'hffff_ffff;
			if (plen > rem) plen = rem;
			rem -= plen;
			off = 0;
			if (a.mode == MODE_LOAD) void'(fetch_line(cl));
			else begin
				base = (cl % e_sets) * MAX_WAYS;
				loc = lookup(cl, base);
				if (wa_en && !a.streaming) begin
					if (loc < 0) begin
						n_load++;
						loc = fetch_line(cl);
					end
				end else if (loc < 0 && wb_en) loc = replace(cl, 1);
				if (wb_en && loc >= 0) drt[base+loc] = 1;
				else begin
					n_evict++;
					push_event(EV_WT, paddr, plen, a.streaming);
				end
			end
		end
		if (expected_q.size() > first) expected_q[$].is_last = 1;
	endfunction

	function void check_event(res_t got);
		res_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected event %p", $time, got);
			fail_cnt++;
			return;
		end
		e = expected_q.pop_front();
		if (got !== e) begin
			$display("%0t: mismatch expected %p actual %p", $time, e, got);
			fail_cnt++;
		end
	endfunction
endclass

module set_assoc_cache_tag_controller_test;
	logic clk, arst_n;
	logic acc_valid, acc_stall, res_valid, res_stall, cfg_we;
	acc_t acc;
	res_t res;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	cache_event_board board;
	bit long_hold;
	int long_hold_len;

	set_assoc_cache_tag_controller dut (
		.clk(clk), .arst_n(arst_n),
		.acc_valid(acc_valid), .acc_stall(acc_stall), .acc(acc),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

	// sink with random stalls and one long hold on request
	initial begin
		int w;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) board.check_event(res);
			if (long_hold) begin
				res_stall <= 1'b1;
				for (int i = 0; i < long_hold_len; i++) @(posedge clk);
				long_hold = 0;
				res_stall <= 1'b0;
			end else begin
				w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
				if (w > 0) begin
					res_stall <= 1'b1;
					for (int i = 0; i < w; i++) begin
						@(posedge clk);
						if (res_valid && !res_stall) board.check_event(res);
					end
					res_stall <= 1'b0;
				end
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	// valid stays high between back to back beats and drops only before a gap
	task automatic send_access(bit md, logic [31:0] addr, int unsigned len, bit nt,
			bit gaps);
		int w;
		acc_t a;
		w = gaps ? $urandom_range(0, 11) : 0;
		if ($urandom_range(0, 2) == 0) w = 0;
		if (w > 0) begin
			acc_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		a.mode = md;
		a.access_addr = addr;
		a.access_length = len[6:0];
		a.streaming = nt;
		acc <= a;
		acc_valid <= 1'b1;
		do @(posedge clk); while (acc_stall);
		board.note_access(a);
	endtask

	task automatic drain();
		int guard;
		acc_valid <= 1'b0;
		guard = 0;
		while (board.expected_q.size() > 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (120) @(posedge clk);
	endtask

	task automatic set_phase(int unsigned sc, int unsigned wy, int unsigned lb,
			int unsigned pl, int unsigned wb, int unsigned wa);
		drain();
		write_reg(CFG_SET_COUNT, sc);
		write_reg(CFG_WAYS, wy);
		write_reg(CFG_LINE_BITS, lb);
		write_reg(CFG_POLICY, pl);
		write_reg(CFG_WB_EN, wb);
		write_reg(CFG_WA_EN, wa);
		cfg_we <= 1'b0;
	endtask

	// mostly addresses from a small pool so lines get reused and evicted
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		case ($urandom_range(0, 9))
			0: a = $urandom;
			1: a = 32'hffff_ffff - $urandom_range(0, 200);
			default: a = ($urandom_range(0, 63) << 7) * ($urandom_range(0, 1) ? 1 : 257)
				+ $urandom_range(0, 127);
		endcase
		return a;
	endfunction

	task automatic random_batch(int n, bit gaps);
		int unsigned len;
		for (int i = 0; i < n; i++) begin
			len = $urandom_range(0, 15) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 64);
			send_access(1'($urandom_range(0, 1)), pick_addr(), len,
				1'($urandom_range(0, 1)), gaps);
		end
	endtask

	initial begin
		board = new();
		long_hold = 0;
		long_hold_len = 0;
		acc_valid = 1'b0;
		acc = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config
		send_access(MODE_LOAD, 32'h0000_0000, 1, 0, 0);
		send_access(MODE_LOAD, 32'h0000_0000, 1, 0, 0);
		send_access(MODE_STORE, 32'h0000_003f, 64, 0, 0);
		send_access(MODE_STORE, 32'h0000_1000, 0, 0, 0);
		send_access(MODE_LOAD, 32'hffff_ffe0, 64, 1, 0);
		send_access(MODE_STORE, 32'hffff_ffff, 127, 1, 0);
		send_access(MODE_LOAD, 32'haaaa_5555, 33, 0, 0);
		send_access(MODE_STORE, 32'h5555_aaaa, 17, 1, 0);
		for (int i = 0; i < 10; i++)
			send_access(MODE_STORE, i * 32'h4000, 8, 0, 0);
		// registers out of range, write-through, no allocate
		set_phase(0, 0, 0, POL_FIFO, 0, 0);
		send_access(MODE_STORE, 32'h0000_0020, 40, 1, 0);
		send_access(MODE_STORE, 32'h0000_0020, 40, 0, 0);
		send_access(MODE_LOAD, 32'h0000_0020, 40, 0, 0);
		set_phase(511, 15, 7, POL_RAND, 1, 0);
		send_access(MODE_STORE, 32'h0001_0000, 64, 0, 0);
		send_access(MODE_LOAD, 32'h0001_0000, 64, 0, 0);

		// random phases across settings
		set_phase(4, 4, 5, POL_RAND, 1, 1);
		random_batch(45, 1);
		set_phase(1, 1, 5, POL_FIFO, 1, 1);
		random_batch(35, 1);
		set_phase(256, 8, 7, POL_MRU, 1, 1);
		random_batch(35, 1);
		set_phase(3, 8, 6, POL_LRU, 1, 1);
		// long receiver hold while sender keeps going
		long_hold_len = 400;
		long_hold = 1;
		random_batch(40, 0);
		set_phase(7, 3, 5, POL_RAND, 1, 0);
		random_batch(35, 1);
		set_phase(2, 2, 6, POL_MRU, 0, 1);
		random_batch(35, 1);
		set_phase(16, 5, 7, POL_FIFO, 1, 0);
		random_batch(35, 1);
		drain();
		set_phase(5, 8, 5, POL_LRU, 1, 1);
		random_batch(70, 1);

		drain();
		if (board.fail_cnt == 0 && board.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
